// ----- rtl/core/rbg_pkg.sv -----
// Shared types, constants and helpers for the random matching bond generator.
// No dependencies; imported by the generator and its checker.
package rbg_pkg;

  // Sizing
  localparam int MAX_SITES  = 1024;
  localparam int MAX_DEGREE = 8;
  localparam int SITE_W     = $clog2(MAX_SITES);
  localparam int CNT_W      = SITE_W + 1;
  localparam int SITE_CNT_W = 11;
  localparam int DEGREE_W   = 4;
  localparam int DEG_CNT_W  = 4;
  localparam int SLOT_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SITE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE     = 1'b1;

  // Register reset values
  localparam logic [SITE_CNT_W-1:0] SITE_COUNT_RST = SITE_CNT_W'(1024);
  localparam logic [DEGREE_W-1:0]   DEGREE_RST     = DEGREE_W'(3);

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_BOND   = 2'd0,
    STATUS_START  = 2'd1,
    STATUS_REJECT = 2'd2
  } status_t;

  // Clamp the site count register into 2..MAX_SITES
  function automatic logic [CNT_W-1:0] eff_sites(input logic [SITE_CNT_W-1:0] n);
    if (n < SITE_CNT_W'(2)) return CNT_W'(2);
    else if (n > SITE_CNT_W'(MAX_SITES)) return CNT_W'(MAX_SITES);
    else return CNT_W'(n);
  endfunction

  // Clamp the degree register into 1..MAX_DEGREE
  function automatic logic [DEGREE_W-1:0] eff_degree(input logic [DEGREE_W-1:0] d);
    if (d < DEGREE_W'(1)) return DEGREE_W'(1);
    else if (d > DEGREE_W'(MAX_DEGREE)) return DEGREE_W'(MAX_DEGREE);
    else return d;
  endfunction

  // Saturating increment of a 4-bit count
  function automatic logic [DEG_CNT_W-1:0] sat_inc(input logic [DEG_CNT_W-1:0] c);
    if (c == '1) return c;
    else return c + DEG_CNT_W'(1);
  endfunction

endpackage

// ----- rtl/core/rbg_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies; used for the pick list and the degree counts.
module rbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/random_matching_bond_generator.sv -----
// Draw item: four reads then four writes of the pick list before the result.
// Rejected draw: result straight from the check. Start item: the clearing sweep
// rewrites both memories, one entry per cycle, then gives the result.
// After rst the block sweeps both memories (input stalled);
// configuration writes are taken at any time. A result may wait while the next
// item is accepted.
module random_matching_bond_generator (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_write_en,
  input  logic [rbg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rbg_pkg::CFG_W-1:0]       cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            func,
  input  logic [rbg_pkg::SITE_W-1:0]      draw_first,
  input  logic [rbg_pkg::SITE_W-1:0]      draw_second,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rbg_pkg::SITE_W-1:0]      site_a,
  output logic [rbg_pkg::SITE_W-1:0]      site_b,
  output logic [rbg_pkg::SLOT_W-1:0]      slot_a,
  output logic [rbg_pkg::SLOT_W-1:0]      slot_b,
  output logic [rbg_pkg::STATUS_W-1:0]    status,
  output logic                            round_end,
  output logic                            graph_done
);

  import rbg_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_RD1, S_RD2, S_RD3,
    S_WR0, S_WR1, S_WR2, S_WR3, S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [SITE_CNT_W-1:0] site_count;
  logic [DEGREE_W-1:0]   degree;

  // graph progress
  logic [CNT_W-1:0]     unpicked;
  logic [SITE_W-1:0]    pairs_in_round;
  logic [DEG_CNT_W-1:0] round_number;
  logic                 complete_flag;

  // clearing sweep
  logic [SITE_W-1:0] clr_idx;
  logic              clr_emit;

  // item under work
  logic              func_r;
  logic [SITE_W-1:0] d1;
  logic [SITE_W-1:0] d2;
  logic [SITE_W-1:0] a_site;
  logic [SITE_W-1:0] b_site;
  logic [SITE_W-1:0] vtop1;
  logic [SITE_W-1:0] ptop2;
  logic [DEG_CNT_W-1:0] sa;
  logic [DEG_CNT_W-1:0] sb;

  // pending result
  logic [SITE_W-1:0]   res_a;
  logic [SITE_W-1:0]   res_b;
  logic [SLOT_W-1:0]   res_slot_a;
  logic [SLOT_W-1:0]   res_slot_b;
  status_t             res_status;
  logic                res_round_end;
  logic                res_done;

  // memory ports
  logic                 pk_we;
  logic [SITE_W-1:0]    pk_waddr;
  logic [SITE_W-1:0]    pk_wdata;
  logic [SITE_W-1:0]    pk_raddr;
  logic [SITE_W-1:0]    pk_rdata;
  logic                 dc_we;
  logic [SITE_W-1:0]    dc_waddr;
  logic [DEG_CNT_W-1:0] dc_wdata;
  logic [SITE_W-1:0]    dc_raddr;
  logic [DEG_CNT_W-1:0] dc_rdata;

  // derived values
  logic [CNT_W-1:0]     sites_eff;
  logic [CNT_W-1:0]     half_sites;
  logic [CNT_W-1:0]     pairs_inc;
  logic                 round_hit;
  logic [DEG_CNT_W-1:0] round_inc;
  logic                 done_hit;
  logic [SITE_W-1:0]    top1;
  logic [SITE_W-1:0]    top2;
  logic [SITE_W-1:0]    b_now;
  logic [SITE_W-1:0]    ptop2_now;
  logic                 reject;
  logic                 out_free;

  rbg_ram #(.WIDTH(SITE_W), .DEPTH(MAX_SITES)) u_pick (
    .clk   (clk),
    .we    (pk_we),
    .waddr (pk_waddr),
    .wdata (pk_wdata),
    .raddr (pk_raddr),
    .rdata (pk_rdata)
  );

  rbg_ram #(.WIDTH(DEG_CNT_W), .DEPTH(MAX_SITES)) u_degree (
    .clk   (clk),
    .we    (dc_we),
    .waddr (dc_waddr),
    .wdata (dc_wdata),
    .raddr (dc_raddr),
    .rdata (dc_rdata)
  );

  // Round and completion tests use the registers as they stand now
  assign sites_eff  = eff_sites(site_count);
  assign half_sites = sites_eff >> 1;
  assign pairs_inc  = {1'b0, pairs_in_round} + CNT_W'(1);
  assign round_hit  = pairs_inc >= half_sites;
  assign round_inc  = sat_inc(round_number);
  assign done_hit   = round_inc >= eff_degree(degree);

  // Top of the unpicked part for each of the two swaps
  assign top1 = unpicked[SITE_W-1:0] - SITE_W'(1);
  assign top2 = unpicked[SITE_W-1:0] - SITE_W'(2);

  // Second swap sees the first swap's write to the first draw's entry
  assign b_now     = (d2 == d1) ? vtop1 : pk_rdata;
  assign ptop2_now = (top2 == d1) ? vtop1 : pk_rdata;

  assign reject = complete_flag
               || (unpicked < CNT_W'(2))
               || (unpicked > CNT_W'(MAX_SITES))
               || ({1'b0, d1} >= unpicked)
               || ({1'b0, d2} >= unpicked - CNT_W'(1));

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Drive the memory ports from the sequencer state
  always_comb begin
    pk_we    = 1'b0;
    pk_waddr = '0;
    pk_wdata = '0;
    pk_raddr = '0;
    dc_we    = 1'b0;
    dc_waddr = '0;
    dc_wdata = '0;
    dc_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        pk_we    = 1'b1;
        pk_waddr = clr_idx;
        pk_wdata = clr_idx;
        dc_we    = 1'b1;
        dc_waddr = clr_idx;
      end
      S_CHECK: pk_raddr = d1;
      S_RD1: begin
        pk_raddr = top1;
        dc_raddr = pk_rdata;
      end
      S_RD2: pk_raddr = d2;
      S_RD3: begin
        pk_raddr = top2;
        dc_raddr = b_now;
      end
      S_WR0: begin
        pk_we    = 1'b1;
        pk_waddr = d1;
        pk_wdata = vtop1;
        dc_we    = 1'b1;
        dc_waddr = a_site;
        dc_wdata = sat_inc(sa);
      end
      S_WR1: begin
        pk_we    = 1'b1;
        pk_waddr = top1;
        pk_wdata = a_site;
        dc_we    = 1'b1;
        dc_waddr = b_site;
        dc_wdata = sat_inc(sb);
      end
      S_WR2: begin
        pk_we    = 1'b1;
        pk_waddr = d2;
        pk_wdata = ptop2;
      end
      S_WR3: begin
        pk_we    = 1'b1;
        pk_waddr = top2;
        pk_wdata = b_site;
      end
      S_IDLE, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer, graph state, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_idx        <= '0;
      clr_emit       <= 1'b0;
      site_count     <= SITE_COUNT_RST;
      degree         <= DEGREE_RST;
      unpicked       <= CNT_W'(MAX_SITES);
      pairs_in_round <= '0;
      round_number   <= '0;
      complete_flag  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // take configuration writes
      if (cfg_write_en) begin
        unique case (cfg_index)
          REG_SITE_COUNT: site_count <= cfg_data[SITE_CNT_W-1:0];
          REG_DEGREE:     degree     <= cfg_data[DEGREE_W-1:0];
          default: begin
          end
        endcase
      end

      // drop a beat once it is taken, unless a new one replaces it
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + SITE_W'(1);
          if (clr_idx == SITE_W'(MAX_SITES - 1)) begin
            // the sweep after reset keeps the reset pick count
            if (clr_emit) begin
              unpicked <= sites_eff;
            end
            pairs_in_round <= '0;
            round_number   <= '0;
            complete_flag  <= 1'b0;
            res_a          <= '0;
            res_b          <= '0;
            res_slot_a     <= '0;
            res_slot_b     <= '0;
            res_status     <= STATUS_START;
            res_round_end  <= 1'b0;
            res_done       <= 1'b0;
            state          <= clr_emit ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            func_r <= func;
            d1     <= draw_first;
            d2     <= draw_second;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!func_r) begin
            clr_idx  <= '0;
            clr_emit <= 1'b1;
            state    <= S_CLEAR;
          end else if (reject) begin
            res_a         <= '0;
            res_b         <= '0;
            res_slot_a    <= '0;
            res_slot_b    <= '0;
            res_status    <= STATUS_REJECT;
            res_round_end <= 1'b0;
            res_done      <= complete_flag;
            state         <= S_DONE;
          end else begin
            state <= S_RD1;
          end
        end
        S_RD1: begin
          a_site <= pk_rdata;
          state  <= S_RD2;
        end
        S_RD2: begin
          vtop1 <= pk_rdata;
          sa    <= dc_rdata;
          state <= S_RD3;
        end
        S_RD3: begin
          b_site <= b_now;
          state  <= S_WR0;
        end
        S_WR0: begin
          ptop2 <= ptop2_now;
          sb    <= dc_rdata;
          state <= S_WR1;
        end
        S_WR1: state <= S_WR2;
        S_WR2: state <= S_WR3;
        S_WR3: begin
          // advance the round bookkeeping
          if (round_hit) begin
            unpicked       <= sites_eff;
            pairs_in_round <= '0;
            round_number   <= round_inc;
            if (done_hit) begin
              complete_flag <= 1'b1;
            end
          end else begin
            unpicked       <= unpicked - CNT_W'(2);
            pairs_in_round <= pairs_inc[SITE_W-1:0];
          end
          res_a         <= a_site;
          res_b         <= b_site;
          res_slot_a    <= sa[SLOT_W-1:0];
          res_slot_b    <= sb[SLOT_W-1:0];
          res_status    <= STATUS_BOND;
          res_round_end <= round_hit;
          res_done      <= complete_flag || (round_hit && done_hit);
          state         <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid  <= 1'b1;
            site_a     <= res_a;
            site_b     <= res_b;
            slot_a     <= res_slot_a;
            slot_b     <= res_slot_b;
            status     <= res_status;
            round_end  <= res_round_end;
            graph_done <= res_done;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/rbg_checker.sv -----
// Port-level checks for the random matching bond generator, bound to its top level.
// Depends on rbg_pkg for status codes and widths.
module rbg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rbg_pkg::SITE_W-1:0]    site_a,
  input logic [rbg_pkg::SITE_W-1:0]    site_b,
  input logic [rbg_pkg::SLOT_W-1:0]    slot_a,
  input logic [rbg_pkg::SLOT_W-1:0]    slot_b,
  input logic [rbg_pkg::STATUS_W-1:0]  status,
  input logic                          round_end,
  input logic                          graph_done
);

  import rbg_pkg::*;

  // A stalled beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(site_a) && $stable(site_b)
      && $stable(status) && $stable(graph_done))
    else $error("output beat changed while stalled");

  // A bond joins two different sites
  a_bond_distinct: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_BOND) |-> site_a != site_b)
    else $error("bond joins a site to itself");

  // A start beat carries an empty graph
  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_START) |-> (site_a == '0) && (site_b == '0)
      && (slot_a == '0) && (slot_b == '0) && !round_end && !graph_done)
    else $error("start beat carries bond fields");

  // A rejected draw never closes a round
  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_REJECT) |-> !round_end && (site_a == '0)
      && (site_b == '0))
    else $error("rejected draw carries bond fields");

  // Completion is only announced together with a round end or on a rejected draw
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    out_valid && graph_done && (status == STATUS_BOND) |-> round_end
      || $past(graph_done))
    else $error("graph completed outside a round end");

endmodule

bind random_matching_bond_generator rbg_checker u_rbg_checker (.*);
